// ===== design/plc_pkg.sv =====
package plc_pkg;

    localparam int NumFrames = 64;
    localparam int FrameW    = $clog2(NumFrames);
    localparam int LinkW     = FrameW + 1;
    localparam int TagW      = 36;
    localparam int PinW      = 8;
    localparam int CntW      = 32;
    localparam int OffW      = 49;
    localparam int SpanW     = 21;
    localparam int BaseW     = 48;
    localparam int CfgAddrW  = 5;
    localparam int CfgDataW  = 64;

    localparam logic [LinkW-1:0] LinkNone = LinkW'(NumFrames);
    localparam logic [PinW-1:0]  PinMax   = {PinW{1'b1}};

    localparam logic [1:0] RegBase   = 2'd0;
    localparam logic [1:0] RegLength = 2'd1;
    localparam logic [1:0] RegShift  = 2'd2;
    localparam logic [1:0] RegFrames = 2'd3;

    localparam logic [2:0] StHit       = 3'd0;
    localparam logic [2:0] StMiss      = 3'd1;
    localparam logic [2:0] StBad       = 3'd2;
    localparam logic [2:0] StAllPinned = 3'd3;
    localparam logic [2:0] StFetchFail = 3'd4;
    localparam logic [2:0] StPinFull   = 3'd5;
    localparam logic [2:0] StUnpinned  = 3'd6;
    localparam logic [2:0] StIgnored   = 3'd7;

    localparam logic CmdPin   = 1'b0;
    localparam logic CmdUnpin = 1'b1;

    typedef struct packed {
        logic [PinW-1:0]  pin;
        logic [LinkW-1:0] prev;
        logic [LinkW-1:0] next;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [FrameW-1:0] addr;
        logic              we_pin;
        logic              we_prev;
        logic              we_next;
        t_entry            data;
    } t_mem_wr;

    typedef struct packed {
        logic              clr;
        logic              wr;
        logic              inv;
        logic [FrameW-1:0] idx;
        logic [TagW-1:0]   tag;
    } t_cam_req;

    typedef struct packed {
        logic [BaseW-1:0] base;
        logic [OffW-1:0]  length;
        logic [4:0]       shift;
        logic [6:0]       frames;
        logic             reinit;
    } t_cfg;

endpackage

// ===== design/plc_cfg.sv =====
module plc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [plc_pkg::CfgAddrW-1:0]  paddr,
    input  logic [plc_pkg::CfgDataW-1:0]  pwdata,
    output logic [plc_pkg::CfgDataW-1:0]  prdata,
    output logic                          pready,
    output plc_pkg::t_cfg                 o_cfg
);

    logic [plc_pkg::BaseW-1:0] r_base;
    logic [plc_pkg::OffW-1:0]  r_length;
    logic [4:0]                r_shift;
    logic [6:0]                r_frames;
    logic                      r_reinit;
    logic                      w_wr;
    logic [1:0]                w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_length <= '0;
            r_shift  <= 5'd16;
            r_frames <= 7'(plc_pkg::NumFrames);
            r_reinit <= 1'b0;
        end else begin
            r_reinit <= 1'b0;
            if (w_wr) begin
                case (w_idx)
                    plc_pkg::RegBase:   r_base   <= pwdata[plc_pkg::BaseW-1:0];
                    plc_pkg::RegLength: r_length <= pwdata[plc_pkg::OffW-1:0];
                    plc_pkg::RegShift:  r_shift  <= pwdata[4:0];
                    plc_pkg::RegFrames: begin
                        r_frames <= pwdata[6:0];
                        r_reinit <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (w_idx)
            plc_pkg::RegBase:   prdata = plc_pkg::CfgDataW'(r_base);
            plc_pkg::RegLength: prdata = plc_pkg::CfgDataW'(r_length);
            plc_pkg::RegShift:  prdata = plc_pkg::CfgDataW'(r_shift);
            plc_pkg::RegFrames: prdata = plc_pkg::CfgDataW'(r_frames);
            default:            prdata = '0;
        endcase
    end

    assign o_cfg.base   = r_base;
    assign o_cfg.length = r_length;
    assign o_cfg.shift  = r_shift;
    assign o_cfg.frames = r_frames;
    assign o_cfg.reinit = r_reinit;

endmodule

// ===== design/plc_cam.sv =====
module plc_cam (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  plc_pkg::t_cam_req                   i_req,
    input  logic                                i_cmp_en,
    input  logic [plc_pkg::TagW-1:0]            i_cmp_tag,
    output logic [plc_pkg::NumFrames-1:0]       o_valid,
    output logic                                o_hit,
    output logic [plc_pkg::FrameW-1:0]          o_hit_idx
);

    logic [plc_pkg::TagW-1:0]      r_tag [plc_pkg::NumFrames];
    logic [plc_pkg::NumFrames-1:0] r_valid;
    logic [plc_pkg::NumFrames-1:0] r_hitv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_valid <= '0;
        end else if (i_req.wr) begin
            r_valid[i_req.idx] <= 1'b1;
        end else if (i_req.inv) begin
            r_valid[i_req.idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_tag[i_req.idx] <= i_req.tag;
        end
    end

    // parallel compare, registered
    always_ff @(posedge i_clk) begin
        if (i_cmp_en) begin
            for (int i = 0; i < plc_pkg::NumFrames; i++) begin
                r_hitv[i] <= r_valid[i] & (r_tag[i] == i_cmp_tag);
            end
        end
    end

    // lowest matching frame wins
    always_comb begin
        o_hit     = |r_hitv;
        o_hit_idx = '0;
        for (int i = plc_pkg::NumFrames - 1; i >= 0; i--) begin
            if (r_hitv[i]) begin
                o_hit_idx = plc_pkg::FrameW'(i);
            end
        end
    end

    assign o_valid = r_valid;

endmodule

// ===== design/plc_lmem.sv =====
module plc_lmem (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_init,
    input  logic [plc_pkg::LinkW-1:0]    i_frames,
    input  logic                         i_rd_en,
    input  logic [plc_pkg::FrameW-1:0]   i_rd_addr,
    input  plc_pkg::t_mem_wr             i_wr,
    output plc_pkg::t_entry              o_rd
);

    logic [plc_pkg::PinW-1:0]      r_pin  [plc_pkg::NumFrames];
    logic [plc_pkg::LinkW-1:0]     r_prev [plc_pkg::NumFrames];
    logic [plc_pkg::LinkW-1:0]     r_next [plc_pkg::NumFrames];
    logic [plc_pkg::NumFrames-1:0] r_iv;
    logic [plc_pkg::PinW-1:0]      r_rd_pin;
    logic [plc_pkg::LinkW-1:0]     r_rd_prev;
    logic [plc_pkg::LinkW-1:0]     r_rd_next;
    logic                          r_rd_iv;
    logic [plc_pkg::FrameW-1:0]    r_rd_addr;
    logic                          w_wr_iv;

    // free chain value of an entry that was not written since init
    function automatic logic [plc_pkg::LinkW-1:0] f_init_next(
        input logic [plc_pkg::FrameW-1:0] a,
        input logic [plc_pkg::LinkW-1:0]  n
    );
        logic [plc_pkg::LinkW-1:0] s;
        s = plc_pkg::LinkW'(a) + plc_pkg::LinkW'(1);
        return (s < n) ? s : plc_pkg::LinkNone;
    endfunction

    assign w_wr_iv = r_iv[i_wr.addr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            r_iv <= '0;
        end else if (i_wr.en) begin
            r_iv[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            if (i_wr.we_pin || !w_wr_iv) begin
                r_pin[i_wr.addr] <= i_wr.we_pin ? i_wr.data.pin : '0;
            end
            if (i_wr.we_prev || !w_wr_iv) begin
                r_prev[i_wr.addr] <= i_wr.we_prev ? i_wr.data.prev : plc_pkg::LinkNone;
            end
            if (i_wr.we_next || !w_wr_iv) begin
                r_next[i_wr.addr] <= i_wr.we_next ? i_wr.data.next
                                                  : f_init_next(i_wr.addr, i_frames);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_pin  <= r_pin[i_rd_addr];
            r_rd_prev <= r_prev[i_rd_addr];
            r_rd_next <= r_next[i_rd_addr];
            r_rd_iv   <= r_iv[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    assign o_rd.pin  = r_rd_iv ? r_rd_pin  : '0;
    assign o_rd.prev = r_rd_iv ? r_rd_prev : plc_pkg::LinkNone;
    assign o_rd.next = r_rd_iv ? r_rd_next : f_init_next(r_rd_addr, i_frames);

endmodule

// ===== design/pinned_lru_page_cache.sv =====
// Frame manager for a page cache with pin counts and an LRU list.
// Input stream s_axis: tuser is the command (pin or unpin), tdata carries the
// byte offset, byte span, frame token and fetch result of one request.
// Output stream m_axis: one result per request, tuser is the status code,
// tdata carries frame, page offset, fetch address and length, the eviction
// flag and the hit, miss, eviction and resident counters after the request.
// Configuration goes through the APB port: region base, region length,
// page shift and frames in use; writing frames in use reinitializes all frames.
// One request is worked on at a time. An unpin reads the pin/link memory and
// may write it; a pin runs a range check and a tag compare, then accesses the
// pin/link memory, which has one read and one write port. A new request is
// taken only in the idle state, after the previous result has gone into the
// output register.
// A finished result waits in the output register while the next request is
// taken; if the receiver stalls, the block holds its next result until the
// output register is free. Reset clears all frames, the LRU list, the free
// stack and the counters; no clearing pass is needed.
module pinned_lru_page_cache (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [79:0]                   s_axis_tdata,  // byte_offset, byte_span,
                                                         // frame_token, fetch_ok
    input  logic [0:0]                    s_axis_tuser,  // cmd
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [199:0]                  m_axis_tdata,  // frame_index, page_offset,
                                                         // fetch_address, fetch_length,
                                                         // evicted, hit_count, miss_count,
                                                         // eviction_count, resident_count
    output logic [2:0]                    m_axis_tuser,  // status
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [plc_pkg::CfgAddrW-1:0]  paddr,
    input  logic [plc_pkg::CfgDataW-1:0]  pwdata,
    output logic [plc_pkg::CfgDataW-1:0]  prdata,
    output logic                          pready
);

    localparam int LinkW  = plc_pkg::LinkW;
    localparam int FrameW = plc_pkg::FrameW;
    localparam int OffW   = plc_pkg::OffW;

    typedef enum logic [3:0] {
        S_IDLE, S_U0, S_U1, S_U2, S_P0, S_P1, S_P2, S_H1,
        S_E1, S_M1, S_RM0, S_RM1, S_RM2, S_FIN, S_DONE
    } t_state;

    plc_pkg::t_cfg     w_cfg;
    plc_pkg::t_cam_req w_cam_req;
    plc_pkg::t_mem_wr  w_mem_wr;
    plc_pkg::t_entry   w_rd;
    logic [plc_pkg::NumFrames-1:0] w_valid;
    logic                          w_hit;
    logic [FrameW-1:0]             w_hit_idx;
    logic                          w_rd_en;
    logic [FrameW-1:0]             w_rd_addr;
    logic                          w_cmp_en;

    t_state                     r_state;
    logic [OffW-1:0]            r_off;
    logic [20:0]                r_span;
    logic [5:0]                 r_tok;
    logic                       r_ok;
    logic [OffW:0]              r_diff;
    logic [21:0]                r_sum;
    logic [plc_pkg::TagW-1:0]   r_tag;
    logic [OffW-1:0]            r_pbase;
    logic [19:0]                r_inpage;
    logic [20:0]                r_psize;
    logic                       r_bad;
    logic [OffW-1:0]            r_avail;
    logic [OffW-1:0]            r_faddr;
    logic [LinkW-1:0]           r_f;
    logic [LinkW-1:0]           r_p;
    logic [LinkW-1:0]           r_nx;
    logic                       r_ret_hit;
    logic [LinkW-1:0]           r_head;
    logic [LinkW-1:0]           r_tail;
    logic [LinkW-1:0]           r_free;
    logic [plc_pkg::CntW-1:0]   r_hits;
    logic [plc_pkg::CntW-1:0]   r_misses;
    logic [plc_pkg::CntW-1:0]   r_evicts;
    logic [LinkW-1:0]           r_resident;
    logic [2:0]                 r_res_status;
    logic [FrameW-1:0]          r_res_fidx;
    logic [19:0]                r_res_poff;
    logic [OffW-1:0]            r_res_faddr;
    logic [20:0]                r_res_flen;
    logic                       r_res_ev;
    logic                       r_out_valid;
    logic [2:0]                 r_out_user;
    logic [199:0]               r_out_data;

    logic [LinkW-1:0]           w_n;
    logic [4:0]                 w_sh;
    logic [20:0]                w_psize;
    logic [OffW-1:0]            w_pmask;
    logic                       w_free_ok;
    logic                       w_tok_ok;
    logic [20:0]                w_flen;

    plc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    plc_cam u_cam (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_cam_req),
        .i_cmp_en  (w_cmp_en),
        .i_cmp_tag (r_tag),
        .o_valid   (w_valid),
        .o_hit     (w_hit),
        .o_hit_idx (w_hit_idx)
    );

    plc_lmem u_lmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_init    (w_cfg.reinit),
        .i_frames  (w_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .i_wr      (w_mem_wr),
        .o_rd      (w_rd)
    );

    // clamped configuration
    always_comb begin
        if (w_cfg.frames == '0) begin
            w_n = LinkW'(1);
        end else if (32'(w_cfg.frames) > 32'(plc_pkg::NumFrames)) begin
            w_n = plc_pkg::LinkNone;
        end else begin
            w_n = LinkW'(w_cfg.frames);
        end
        if (w_cfg.shift < 5'd12) begin
            w_sh = 5'd12;
        end else if (w_cfg.shift > 5'd20) begin
            w_sh = 5'd20;
        end else begin
            w_sh = w_cfg.shift;
        end
    end

    assign w_psize   = 21'(1) << w_sh;
    assign w_pmask   = OffW'(w_psize) - OffW'(1);
    assign w_free_ok = (r_free != plc_pkg::LinkNone) && (r_free < w_n);
    assign w_tok_ok  = (32'(r_tok) < 32'(w_n)) && w_valid[FrameW'(r_tok)];
    assign w_flen    = (r_avail < OffW'(r_psize)) ? 21'(r_avail) : r_psize;
    assign w_cmp_en  = (r_state == S_P1);

    // memory read issue
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        case (r_state)
            S_U0: begin
                w_rd_en   = w_tok_ok;
                w_rd_addr = FrameW'(r_tok);
            end
            S_P2: begin
                w_rd_en = !r_bad;
                if (w_hit) begin
                    w_rd_addr = w_hit_idx;
                end else if (w_free_ok) begin
                    w_rd_addr = r_free[FrameW-1:0];
                end else begin
                    w_rd_addr = r_tail[FrameW-1:0];
                end
            end
            default: ;
        endcase
    end

    // memory and tag writes
    always_comb begin
        w_mem_wr           = '0;
        w_mem_wr.addr      = r_f[FrameW-1:0];
        w_mem_wr.data.prev = plc_pkg::LinkNone;
        w_mem_wr.data.next = plc_pkg::LinkNone;
        w_cam_req          = '0;
        w_cam_req.clr      = w_cfg.reinit;
        w_cam_req.idx      = r_f[FrameW-1:0];
        w_cam_req.tag      = r_tag;
        case (r_state)
            S_U1: begin
                if (w_rd.pin == plc_pkg::PinW'(1)) begin
                    w_mem_wr.en        = 1'b1;
                    w_mem_wr.we_pin    = 1'b1;
                    w_mem_wr.we_prev   = 1'b1;
                    w_mem_wr.we_next   = 1'b1;
                    w_mem_wr.data.pin  = '0;
                    w_mem_wr.data.next = r_head;
                end else if (w_rd.pin != '0) begin
                    w_mem_wr.en       = 1'b1;
                    w_mem_wr.we_pin   = 1'b1;
                    w_mem_wr.data.pin = w_rd.pin - plc_pkg::PinW'(1);
                end
            end
            S_U2: begin
                w_mem_wr.en        = 1'b1;
                w_mem_wr.addr      = r_head[FrameW-1:0];
                w_mem_wr.we_prev   = 1'b1;
                w_mem_wr.data.prev = r_f;
            end
            S_H1: begin
                if (w_rd.pin != plc_pkg::PinMax && w_rd.pin != '0) begin
                    w_mem_wr.en       = 1'b1;
                    w_mem_wr.we_pin   = 1'b1;
                    w_mem_wr.data.pin = w_rd.pin + plc_pkg::PinW'(1);
                end
            end
            S_E1: begin
                w_cam_req.inv = 1'b1;
            end
            S_RM0: begin
                if (r_p != plc_pkg::LinkNone) begin
                    w_mem_wr.en        = 1'b1;
                    w_mem_wr.addr      = r_p[FrameW-1:0];
                    w_mem_wr.we_next   = 1'b1;
                    w_mem_wr.data.next = r_nx;
                end
            end
            S_RM1: begin
                if (r_nx != plc_pkg::LinkNone) begin
                    w_mem_wr.en        = 1'b1;
                    w_mem_wr.addr      = r_nx[FrameW-1:0];
                    w_mem_wr.we_prev   = 1'b1;
                    w_mem_wr.data.prev = r_p;
                end
            end
            S_RM2: begin
                w_mem_wr.en       = 1'b1;
                w_mem_wr.we_pin   = 1'b1;
                w_mem_wr.we_prev  = 1'b1;
                w_mem_wr.we_next  = 1'b1;
                w_mem_wr.data.pin = plc_pkg::PinW'(1);
            end
            S_FIN: begin
                w_mem_wr.en      = 1'b1;
                w_mem_wr.we_pin  = 1'b1;
                w_mem_wr.we_prev = 1'b1;
                w_mem_wr.we_next = 1'b1;
                if (r_ok) begin
                    w_mem_wr.data.pin = plc_pkg::PinW'(1);
                    w_cam_req.wr      = 1'b1;
                end else begin
                    w_mem_wr.data.pin  = '0;
                    w_mem_wr.data.next = r_free;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= plc_pkg::LinkNone;
            r_tail      <= plc_pkg::LinkNone;
            r_free      <= '0;
            r_resident  <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg.reinit) begin
                r_head     <= plc_pkg::LinkNone;
                r_tail     <= plc_pkg::LinkNone;
                r_free     <= '0;
                r_resident <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_off        <= s_axis_tdata[48:0];
                        r_span       <= s_axis_tdata[69:49];
                        r_tok        <= s_axis_tdata[75:70];
                        r_ok         <= s_axis_tdata[76];
                        r_res_status <= plc_pkg::StIgnored;
                        r_res_fidx   <= '0;
                        r_res_poff   <= '0;
                        r_res_faddr  <= '0;
                        r_res_flen   <= '0;
                        r_res_ev     <= 1'b0;
                        r_state      <= (s_axis_tuser[0] == plc_pkg::CmdUnpin) ? S_U0 : S_P0;
                    end
                end
                S_U0: begin
                    r_f     <= LinkW'(r_tok);
                    r_state <= w_tok_ok ? S_U1 : S_DONE;
                end
                S_U1: begin
                    if (w_rd.pin == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_res_status <= plc_pkg::StUnpinned;
                        r_res_fidx   <= r_f[FrameW-1:0];
                        r_state      <= S_DONE;
                        if (w_rd.pin == plc_pkg::PinW'(1)) begin
                            if (r_head != plc_pkg::LinkNone) begin
                                r_state <= S_U2;
                            end else begin
                                r_head <= r_f;
                                r_tail <= r_f;
                            end
                        end
                    end
                end
                S_U2: begin
                    r_head  <= r_f;
                    r_state <= S_DONE;
                end
                S_P0: begin
                    r_diff   <= {1'b0, w_cfg.length} - {1'b0, r_off};
                    r_inpage <= r_off[19:0] & w_pmask[19:0];
                    r_sum    <= 22'(r_off[19:0] & w_pmask[19:0]) + 22'(r_span);
                    r_tag    <= plc_pkg::TagW'(r_off >> w_sh);
                    r_pbase  <= r_off & ~w_pmask;
                    r_psize  <= w_psize;
                    r_state  <= S_P1;
                end
                S_P1: begin
                    r_bad   <= (r_span == '0) || r_diff[OffW] ||
                               (OffW'(r_span) > r_diff[OffW-1:0]) ||
                               (r_sum > 22'(r_psize));
                    r_avail <= w_cfg.length - r_pbase;
                    r_faddr <= OffW'(w_cfg.base) + r_pbase;
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_state <= S_DONE;
                    if (r_bad) begin
                        r_res_status <= plc_pkg::StBad;
                    end else begin
                        r_res_poff <= r_inpage;
                        if (w_hit) begin
                            r_f        <= LinkW'(w_hit_idx);
                            r_res_fidx <= w_hit_idx;
                            r_state    <= S_H1;
                        end else if (w_free_ok) begin
                            r_f     <= r_free;
                            r_state <= S_M1;
                        end else if (r_tail != plc_pkg::LinkNone) begin
                            r_f     <= r_tail;
                            r_state <= S_E1;
                        end else begin
                            r_res_status <= plc_pkg::StAllPinned;
                            r_res_poff   <= '0;
                        end
                    end
                end
                S_H1: begin
                    if (w_rd.pin == plc_pkg::PinMax) begin
                        r_res_status <= plc_pkg::StPinFull;
                        r_state      <= S_DONE;
                    end else if (w_rd.pin == '0) begin
                        r_p       <= w_rd.prev;
                        r_nx      <= w_rd.next;
                        r_ret_hit <= 1'b1;
                        r_state   <= S_RM0;
                    end else begin
                        if (r_hits != '1) begin
                            r_hits <= r_hits + plc_pkg::CntW'(1);
                        end
                        r_res_status <= plc_pkg::StHit;
                        r_state      <= S_DONE;
                    end
                end
                S_M1: begin
                    r_free  <= w_rd.next;
                    r_state <= S_FIN;
                end
                S_E1: begin
                    r_p       <= w_rd.prev;
                    r_nx      <= w_rd.next;
                    r_ret_hit <= 1'b0;
                    r_res_ev  <= 1'b1;
                    if (r_resident != '0) begin
                        r_resident <= r_resident - LinkW'(1);
                    end
                    if (r_evicts != '1) begin
                        r_evicts <= r_evicts + plc_pkg::CntW'(1);
                    end
                    r_state <= S_RM0;
                end
                S_RM0: begin
                    if (r_p == plc_pkg::LinkNone) begin
                        r_head <= r_nx;
                    end
                    r_state <= S_RM1;
                end
                S_RM1: begin
                    if (r_nx == plc_pkg::LinkNone) begin
                        r_tail <= r_p;
                    end
                    r_state <= r_ret_hit ? S_RM2 : S_FIN;
                end
                S_RM2: begin
                    if (r_hits != '1) begin
                        r_hits <= r_hits + plc_pkg::CntW'(1);
                    end
                    r_res_status <= plc_pkg::StHit;
                    r_state      <= S_DONE;
                end
                S_FIN: begin
                    r_res_faddr <= r_faddr;
                    r_res_flen  <= w_flen;
                    if (r_ok) begin
                        if (r_resident != '1) begin
                            r_resident <= r_resident + LinkW'(1);
                        end
                        if (r_misses != '1) begin
                            r_misses <= r_misses + plc_pkg::CntW'(1);
                        end
                        r_res_status <= plc_pkg::StMiss;
                        r_res_fidx   <= r_f[FrameW-1:0];
                    end else begin
                        r_free       <= r_f;
                        r_res_status <= plc_pkg::StFetchFail;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_user  <= r_res_status;
                        r_out_data  <= {7'(r_resident), r_evicts, r_misses, r_hits,
                                        r_res_ev, r_res_flen, r_res_faddr,
                                        r_res_poff, 6'(r_res_fidx)};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule
